FILE: sv/route_table_with_aging_defines.svh
// Assertion macros used by the route table top level.
`ifndef ROUTE_TABLE_WITH_AGING_DEFINES_SVH
`define ROUTE_TABLE_WITH_AGING_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define RTA_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked at every rising clock edge outside reset.
`define RTA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/rta_pkg.sv
// Types, opcodes and constants of the route table with aging.
`default_nettype none

package rta_pkg;

   // Default table depth and reset value of the timeout register.
   localparam int          ENTRIES_DEFAULT = 64;
   localparam logic [15:0] TIMEOUT_RESET   = 16'd1000;
   localparam logic [6:0]  REMOVED_MAX     = 7'd127;

   // Operation codes carried by a request beat.
   typedef enum logic [1:0] {
      OP_UPDATE = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_TICK   = 2'd2,
      OP_FILTER = 2'd3
   } op_type;

   // One stored route entry.
   typedef struct packed {
      logic [31:0] node_key;
      logic [31:0] seen;
      logic [7:0]  iface;
      logic [15:0] next_hop;
      logic [15:0] seq;
      logic [15:0] hops;
      logic [31:0] bytes;
   } entry_type;

   // A captured request.
   typedef struct packed {
      op_type      op;
      logic [31:0] node_key;
      logic [7:0]  iface;
      logic [15:0] next_hop;
      logic [15:0] seq_in;
      logic [15:0] hops_in;
      logic [31:0] bytes_in;
      logic [31:0] now_secs;
   } req_type;

   // One response beat.
   typedef struct packed {
      logic        found;
      logic        table_full;
      logic [15:0] hops_out;
      logic [7:0]  iface_out;
      logic [15:0] next_hop_out;
      logic [15:0] seq_out;
      logic [31:0] bytes_out;
      logic [6:0]  removed_count;
      logic [15:0] filter_word;
   } rsp_type;

   // Per-entry verdict of the scan unit.
   typedef struct packed {
      logic        key_hit;
      logic        aged;
      logic [15:0] bloom_bits;
   } scan_status_type;

endpackage

`default_nettype wire

FILE: sv/rta_ifaces.sv
// Channel interfaces of the route table: request, response and register write.
`default_nettype none

// Request channel.
interface rta_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] node_key;
   logic [7:0]  iface;
   logic [15:0] next_hop;
   logic [15:0] seq_in;
   logic [15:0] hops_in;
   logic [31:0] bytes_in;
   logic [31:0] now_secs;

   modport source (
      output valid, op, node_key, iface, next_hop, seq_in, hops_in, bytes_in, now_secs,
      input  ready
   );
   modport sink (
      input  valid, op, node_key, iface, next_hop, seq_in, hops_in, bytes_in, now_secs,
      output ready
   );
endinterface

// Response channel.
interface rta_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic        table_full;
   logic [15:0] hops_out;
   logic [7:0]  iface_out;
   logic [15:0] next_hop_out;
   logic [15:0] seq_out;
   logic [31:0] bytes_out;
   logic [6:0]  removed_count;
   logic [15:0] filter_word;

   modport source (
      output valid, found, table_full, hops_out, iface_out, next_hop_out, seq_out,
             bytes_out, removed_count, filter_word,
      input  ready
   );
   modport sink (
      input  valid, found, table_full, hops_out, iface_out, next_hop_out, seq_out,
             bytes_out, removed_count, filter_word,
      output ready
   );
endinterface

// Register write channel for the timeout.
interface rta_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] timeout_secs;

   modport source (output valid, timeout_secs, input ready);
   modport sink (input valid, timeout_secs, output ready);
endinterface

`default_nettype wire

FILE: sv/rta_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: sv/rta_scan_unit.sv
// Shared per-entry evaluator: key match, age test and Bloom bit of one entry.
`default_nettype none

module rta_scan_unit (
   input  wire rta_pkg::entry_type       entry,
   input  wire logic                     entry_valid,
   input  wire logic [31:0]              query_key,
   input  wire logic [7:0]               query_iface,
   input  wire logic [31:0]              now_secs,
   input  wire logic [15:0]              timeout_secs,
   output rta_pkg::scan_status_type      status
);

   logic [32:0] expiry;

   // The expiry time is kept at 33 bits so that it never wraps.
   assign expiry = {1'b0, entry.seen} + {17'd0, timeout_secs};

   always_comb begin
      status.key_hit    = entry_valid && (entry.node_key == query_key);
      status.aged       = entry_valid && (expiry < {1'b0, now_secs});
      status.bloom_bits = '0;
      if (entry_valid && (entry.iface == query_iface)) begin
         status.bloom_bits[entry.node_key[3:0]] = 1'b1;
      end
   end

endmodule

`default_nettype wire

FILE: sv/route_table_with_aging.sv
// Top level of the hop-count route table with aging.
//
// A table of ENTRIES route entries keyed by a 32-bit node id, held in one RAM
// with a valid bit per entry in flip-flops. Every request (update, lookup,
// aging tick or filter query) walks the whole table through the single RAM
// read port, one entry per cycle, with one shared evaluator judging each entry.
// A request therefore passes a start step, a read of every entry judged once its
// registered read data arrives, and a finish step that waits for the response
// register to be free, then writes back and loads that register. The
// request channel is ready only while no walk is running; a response may wait
// in its output register while the next request is accepted. The timeout
// register resets to 1000 and may be written whenever the block is idle.
`default_nettype none

`include "route_table_with_aging_defines.svh"

module route_table_with_aging #(
   parameter int ENTRIES = rta_pkg::ENTRIES_DEFAULT
) (
   input wire logic   clock,
   input wire logic   reset,
   rta_req_if.sink    req_chan,
   rta_rsp_if.source  rsp_chan,
   rta_csr_if.sink    csr_chan
);

   localparam int               IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST  = IDX_W'(ENTRIES - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type                 state_ff, state_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic                      issued_all_ff, issued_all_in;
   logic                      chk_ff, chk_in;
   logic [IDX_W-1:0]          chk_idx_ff, chk_idx_in;
   logic [ENTRIES-1:0]        valid_ff, valid_in;
   logic                      hit_ff, hit_in;
   logic [IDX_W-1:0]          hit_idx_ff, hit_idx_in;
   rta_pkg::entry_type        hit_ent_ff, hit_ent_in;
   logic                      free_ff, free_in;
   logic [IDX_W-1:0]          free_idx_ff, free_idx_in;
   logic [6:0]                cnt_ff, cnt_in;
   logic [15:0]               bloom_ff, bloom_in;
   rta_pkg::req_type          req_ff, req_in;
   logic [15:0]               timeout_ff, timeout_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   rta_pkg::rsp_type          rsp_ff, rsp_in;

   logic                      wr_en;
   logic [IDX_W-1:0]          wr_addr;
   rta_pkg::entry_type        wr_data;
   logic                      rd_en;
   rta_pkg::entry_type        rd_data;
   rta_pkg::entry_type        upd_entry;
   rta_pkg::scan_status_type  status;

   // Copies the entry fields of a stored record into a response.
   function automatic rta_pkg::rsp_type entry_rsp(input rta_pkg::entry_type e);
      rta_pkg::rsp_type r;
      r              = '0;
      r.hops_out     = e.hops;
      r.iface_out    = e.iface;
      r.next_hop_out = e.next_hop;
      r.seq_out      = e.seq;
      r.bytes_out    = e.bytes;
      return r;
   endfunction

   // Route entry storage.
   rta_ram #(
      .WIDTH ($bits(rta_pkg::entry_type)),
      .DEPTH (ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   // Shared evaluator for the entry just read.
   rta_scan_unit u_scan (
      .entry        (rd_data),
      .entry_valid  (valid_ff[chk_idx_ff]),
      .query_key    (req_ff.node_key),
      .query_iface  (req_ff.iface),
      .now_secs     (req_ff.now_secs),
      .timeout_secs (timeout_ff),
      .status       (status)
   );

   // Hit entry as an update leaves it.
   always_comb begin
      upd_entry = hit_ent_ff;
      if (req_ff.hops_in < hit_ent_ff.hops) begin
         upd_entry.hops     = req_ff.hops_in;
         upd_entry.iface    = req_ff.iface;
         upd_entry.next_hop = req_ff.next_hop;
      end
      upd_entry.seen  = req_ff.now_secs;
      upd_entry.bytes = hit_ent_ff.bytes + req_ff.bytes_in;
   end

   // Handshake outputs.
   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.found         = rsp_ff.found;
   assign rsp_chan.table_full    = rsp_ff.table_full;
   assign rsp_chan.hops_out      = rsp_ff.hops_out;
   assign rsp_chan.iface_out     = rsp_ff.iface_out;
   assign rsp_chan.next_hop_out  = rsp_ff.next_hop_out;
   assign rsp_chan.seq_out       = rsp_ff.seq_out;
   assign rsp_chan.bytes_out     = rsp_ff.bytes_out;
   assign rsp_chan.removed_count = rsp_ff.removed_count;
   assign rsp_chan.filter_word   = rsp_ff.filter_word;

   // Sequencer: accept, walk the table, then write back and respond.
   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      issued_all_in = issued_all_ff;
      chk_in        = 1'b0;
      chk_idx_in    = idx_ff;
      valid_in      = valid_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_ent_in    = hit_ent_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      cnt_in        = cnt_ff;
      bloom_in      = bloom_ff;
      req_in        = req_ff;
      timeout_in    = timeout_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = hit_idx_ff;
      wr_data       = upd_entry;
      rd_en         = 1'b0;

      // Register write beat.
      if (csr_chan.valid) begin
         timeout_in = csr_chan.timeout_secs;
      end

      // Response beat taken downstream.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) begin
               req_in.op       = rta_pkg::op_type'(req_chan.op);
               req_in.node_key = req_chan.node_key;
               req_in.iface    = req_chan.iface;
               req_in.next_hop = req_chan.next_hop;
               req_in.seq_in   = req_chan.seq_in;
               req_in.hops_in  = req_chan.hops_in;
               req_in.bytes_in = req_chan.bytes_in;
               req_in.now_secs = req_chan.now_secs;
               idx_in          = '0;
               issued_all_in   = 1'b0;
               hit_in          = 1'b0;
               free_in         = 1'b0;
               cnt_in          = '0;
               bloom_in        = '0;
               state_in        = ST_SCAN;
            end
         end

         ST_SCAN: begin
            // Issue one read per cycle until the last entry is addressed.
            if (!issued_all_ff) begin
               rd_en  = 1'b1;
               chk_in = 1'b1;
               idx_in = idx_ff + 1'b1;
               if (idx_ff == LAST) begin
                  issued_all_in = 1'b1;
               end
            end

            // Judge the entry whose read data is now present.
            if (chk_ff) begin
               case (req_ff.op)
                  rta_pkg::OP_UPDATE, rta_pkg::OP_LOOKUP: begin
                     if (status.key_hit && !hit_ff) begin
                        hit_in     = 1'b1;
                        hit_idx_in = chk_idx_ff;
                        hit_ent_in = rd_data;
                     end
                     if (!valid_ff[chk_idx_ff] && !free_ff) begin
                        free_in     = 1'b1;
                        free_idx_in = chk_idx_ff;
                     end
                  end
                  rta_pkg::OP_TICK: begin
                     if (status.aged) begin
                        valid_in[chk_idx_ff] = 1'b0;
                        if (cnt_ff != rta_pkg::REMOVED_MAX) begin
                           cnt_in = cnt_ff + 7'd1;
                        end
                     end
                  end
                  rta_pkg::OP_FILTER: begin
                     bloom_in = bloom_ff | status.bloom_bits;
                  end
                  default: begin
                     bloom_in = bloom_ff;
                  end
               endcase
               if (chk_idx_ff == LAST) begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            // Wait until the response register is free.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               state_in     = ST_IDLE;
               case (req_ff.op)
                  rta_pkg::OP_UPDATE: begin
                     if (hit_ff) begin
                        wr_en        = 1'b1;
                        wr_addr      = hit_idx_ff;
                        wr_data      = upd_entry;
                        rsp_in       = entry_rsp(upd_entry);
                        rsp_in.found = 1'b1;
                     end else if (free_ff) begin
                        wr_en                 = 1'b1;
                        wr_addr               = free_idx_ff;
                        wr_data.node_key      = req_ff.node_key;
                        wr_data.seen          = req_ff.now_secs;
                        wr_data.iface         = req_ff.iface;
                        wr_data.next_hop      = req_ff.next_hop;
                        wr_data.seq           = req_ff.seq_in;
                        wr_data.hops          = req_ff.hops_in;
                        wr_data.bytes         = req_ff.bytes_in;
                        valid_in[free_idx_ff] = 1'b1;
                        rsp_in                = entry_rsp(wr_data);
                     end else begin
                        rsp_in.table_full = 1'b1;
                     end
                  end
                  rta_pkg::OP_LOOKUP: begin
                     if (hit_ff) begin
                        rsp_in       = entry_rsp(hit_ent_ff);
                        rsp_in.found = 1'b1;
                     end
                  end
                  rta_pkg::OP_TICK: begin
                     rsp_in.removed_count = cnt_ff;
                  end
                  rta_pkg::OP_FILTER: begin
                     rsp_in.filter_word = bloom_ff;
                  end
                  default: begin
                     rsp_in = '0;
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs; reset clears control state only.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         issued_all_ff <= 1'b0;
         chk_ff        <= 1'b0;
         valid_ff      <= '0;
         hit_ff        <= 1'b0;
         free_ff       <= 1'b0;
         timeout_ff    <= rta_pkg::TIMEOUT_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issued_all_ff <= issued_all_in;
         chk_ff        <= chk_in;
         valid_ff      <= valid_in;
         hit_ff        <= hit_in;
         free_ff       <= free_in;
         timeout_ff    <= timeout_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      idx_ff      <= idx_in;
      chk_idx_ff  <= chk_idx_in;
      hit_idx_ff  <= hit_idx_in;
      hit_ent_ff  <= hit_ent_in;
      free_idx_ff <= free_idx_in;
      cnt_ff      <= cnt_in;
      bloom_ff    <= bloom_in;
      req_ff      <= req_in;
      rsp_ff      <= rsp_in;
   end

   // A new response only ever comes out of the finishing step.
   `RTA_ASSERT_IMPLY(a_rsp_from_finish, clock, reset, $rose(rsp_valid_ff), $past(state_ff == ST_FINISH), "response raised outside finish")

   // A captured hit always points at a live entry when it is used.
   `RTA_ASSERT_IMPLY(a_hit_is_valid, clock, reset, (state_ff == ST_FINISH) && hit_ff, valid_ff[hit_idx_ff], "hit slot not valid")

   // Finishing a request fills at most one slot.
   `RTA_ASSERT_NEXT(a_one_insert, clock, reset, state_ff == ST_FINISH, $countones(valid_ff) <= $past($countones(valid_ff)) + 1, "more than one slot filled")

endmodule

`default_nettype wire
